### rtl/core/fuls_pkg.sv
// shared constants and types of the first unique letter stream block
`default_nettype none

package fuls_pkg;

	localparam int LETTER_W          = 5;
	localparam int ALPHABET_SIZE_DEF = 26;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic pop;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic queue_empty;
		logic head_dup;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/fuls_ctrl.sv
// controller state machine: accept, read queue head, drop repeated heads, load result
`default_nettype none

module fuls_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  fuls_pkg::sts_t     sts,
	output fuls_pkg::cmd_t     cmd
);
	import fuls_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		cmd          = '0;
		req_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nx   = ST_READ;
				end
			end
			ST_READ: begin
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.queue_empty && sts.head_dup) begin
					cmd.pop  = 1'b1;
					state_nx = ST_READ;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/fuls_dp.sv
// datapath: letter flags, first-seen order queue, ring pointers and result register
`default_nettype none

module fuls_dp #(
	parameter int ALPHABET_SIZE = fuls_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  fuls_pkg::cmd_t                     cmd,
	output fuls_pkg::sts_t                     sts,
	input  wire logic [fuls_pkg::LETTER_W-1:0] letter,
	input  wire logic                          first_of_string,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               found,
	output logic [fuls_pkg::LETTER_W-1:0]      unique_letter
);
	import fuls_pkg::*;

	localparam int IW = $clog2(ALPHABET_SIZE);
	localparam int FW = $clog2(ALPHABET_SIZE + 1);

	// seen_q: count >= 1, dup_q: count >= 2
	logic [ALPHABET_SIZE-1:0] seen_q;
	logic [ALPHABET_SIZE-1:0] dup_q;
	logic [ALPHABET_SIZE-1:0] seen_base;
	logic [ALPHABET_SIZE-1:0] dup_base;
	logic [ALPHABET_SIZE-1:0] seen_nx;
	logic [ALPHABET_SIZE-1:0] dup_nx;

	logic [LETTER_W-1:0] queue_mem [ALPHABET_SIZE];
	logic [LETTER_W-1:0] head_rd_q;

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [FW-1:0] fill_q;
	logic [IW-1:0] head_base;
	logic [IW-1:0] tail_base;
	logic [FW-1:0] fill_base;

	logic          in_range;
	logic [IW-1:0] idx;
	logic          push;
	logic          rsp_valid_q;
	logic          found_q;
	logic [LETTER_W-1:0] unique_q;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos);
		ring_next = (pos == IW'(ALPHABET_SIZE - 1)) ? '0 : pos + IW'(1);
	endfunction

	always_comb begin
		seen_base = first_of_string ? '0 : seen_q;
		dup_base  = first_of_string ? '0 : dup_q;
		head_base = first_of_string ? '0 : head_q;
		tail_base = first_of_string ? '0 : tail_q;
		fill_base = first_of_string ? '0 : fill_q;
		in_range  = {1'b0, letter} < (LETTER_W + 1)'(ALPHABET_SIZE);
		idx       = letter[IW-1:0];
		push      = in_range && !seen_base[idx] && (fill_base < FW'(ALPHABET_SIZE));
		seen_nx   = seen_base;
		dup_nx    = dup_base;
		if (in_range) begin
			if (seen_base[idx]) begin
				dup_nx[idx] = 1'b1;
			end
			seen_nx[idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			dup_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (cmd.accept) begin
			seen_q <= seen_nx;
			dup_q  <= dup_nx;
			head_q <= head_base;
			tail_q <= push ? ring_next(tail_base) : tail_base;
			fill_q <= push ? fill_base + FW'(1) : fill_base;
		end else if (cmd.pop) begin
			head_q <= ring_next(head_q);
			fill_q <= fill_q - FW'(1);
		end
	end

	// order queue, one write port at the tail, one registered read at the head
	always_ff @(posedge clk) begin
		if (cmd.accept && push) begin
			queue_mem[tail_base] <= letter;
		end
		head_rd_q <= queue_mem[head_q];
	end

	assign sts.queue_empty = (fill_q == '0);
	assign sts.head_dup    = dup_q[head_rd_q[IW-1:0]];
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q  <= (fill_q != '0);
			unique_q <= (fill_q != '0) ? head_rd_q : '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign found         = found_q;
	assign unique_letter = unique_q;

endmodule

`default_nettype wire

### rtl/core/first_unique_letter_stream.sv
// top level of the first unique letter stream block
//
//  channel   signals                          direction  transfer when
//  req       req_valid req_stall letter        in         req_valid && !req_stall
//            first_of_string
//  rsp       rsp_valid rsp_stall found         out        rsp_valid && !rsp_stall
//            unique_letter
//
// one letter is taken at a time: it passes the idle, read and check states of the
// controller, and each repeated letter dropped from the head of the order queue adds
// another read and check; that loop is set by the registered read port of the queue
// memory
// each queued letter is pushed by its own item and dropped at most once
// arst_n clears the letter flags, pointers and fill count; queue entries are not cleared
// a stalled rsp only holds the block when a new result is ready and the old one waits
`default_nettype none

module first_unique_letter_stream #(
	parameter int ALPHABET_SIZE = fuls_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [fuls_pkg::LETTER_W-1:0] letter,
	input  wire logic                          first_of_string,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               found,
	output logic [fuls_pkg::LETTER_W-1:0]      unique_letter
);
	import fuls_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing of accept, head read and head drop
	fuls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// letter flags, order queue and result register
	fuls_dp #(
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.letter          (letter),
		.first_of_string (first_of_string),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.found           (found),
		.unique_letter   (unique_letter)
	);

	// a letter is taken only on a req transfer
	a_accept_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (req_valid && !req_stall))
		else $error("letter taken without a req transfer");

	// the head is only dropped from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.queue_empty)
		else $error("head dropped from an empty queue");

	// a new result never overwrites one that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a waiting result");

	// rsp_valid only rises after a result load
	a_rsp_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.load_out))
		else $error("rsp_valid rose without a result load");

endmodule

`default_nettype wire

### test/tb_first_unique_letter_stream.sv
// testbench of the first unique letter stream block: directed table, random strings, checker
`timescale 1ns / 100ps

module tb;

	localparam int ALPHA       = fuls_pkg::ALPHABET_SIZE_DEF;
	localparam int LW          = fuls_pkg::LETTER_W;
	localparam int TOTAL_ITEMS = 450;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;

	// one answer of the block
	typedef struct packed {
		logic          found;
		logic [LW-1:0] letter;
	} answer_t;

	// directed stimulus row; typed rows carry their own answer, the rest use the predictor
	typedef struct packed {
		logic [LW-1:0] code;
		logic          restart;
		logic          typed;
		logic          exp_found;
		logic [LW-1:0] exp_letter;
	} stim_row_t;

	localparam int N_DIRECTED = 17;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{5'd0,  1'b0, 1'b1, 1'b1, 5'd0},   // first letter after reset is unique
		'{5'd0,  1'b0, 1'b1, 1'b0, 5'd0},   // same letter again, nothing unique
		'{5'd25, 1'b1, 1'b1, 1'b1, 5'd25},  // new string starts clean, top letter
		'{5'd31, 1'b0, 1'b1, 1'b1, 5'd25},  // out of range code with all bits set is ignored
		'{5'd26, 1'b1, 1'b1, 1'b0, 5'd0},   // clear with an ignored code leaves nothing
		'{5'd1,  1'b0, 1'b1, 1'b1, 5'd1},
		'{5'd2,  1'b0, 1'b0, 1'b0, 5'd0},
		'{5'd1,  1'b0, 1'b1, 1'b1, 5'd2},   // repeated head dropped
		'{5'd2,  1'b0, 1'b1, 1'b0, 5'd0},
		'{5'd1,  1'b0, 1'b1, 1'b0, 5'd0},   // third sighting, count stays saturated
		'{5'd3,  1'b0, 1'b1, 1'b1, 5'd3},
		'{5'd30, 1'b1, 1'b1, 1'b0, 5'd0},   // clear plus out of range code
		'{5'd16, 1'b0, 1'b0, 1'b0, 5'd0},
		'{5'd15, 1'b0, 1'b0, 1'b0, 5'd0},
		'{5'd16, 1'b0, 1'b1, 1'b1, 5'd15},
		'{5'd15, 1'b0, 1'b1, 1'b0, 5'd0},
		'{5'd8,  1'b0, 1'b0, 1'b0, 5'd0}
	};

	logic          clk             = 1'b0;
	logic          arst_n          = 1'b0;
	logic          req_valid       = 1'b0;
	logic          req_stall;
	logic [LW-1:0] letter          = '0;
	logic          first_of_string = 1'b0;
	logic          rsp_valid;
	logic          rsp_stall       = 1'b0;
	logic          found;
	logic [LW-1:0] unique_letter;

	// typed answer that travels along with the current request
	logic          item_typed  = 1'b0;
	logic          item_found  = 1'b0;
	logic [LW-1:0] item_letter = '0;

	// both sides stop idling while this is set
	logic calm = 1'b0;

	// predictor state: saturating sighting counts and first-seen order ring
	logic [1:0]    letter_hits   [ALPHA];
	logic [LW-1:0] arrival_order [ALPHA];
	int            order_head;
	int            order_tail;
	int            order_fill;

	answer_t pending_answers [$];
	int      error_count = 0;
	int      sent_count  = 0;
	int      quiet_cycles = 0;

	always #2 clk = ~clk;

	first_unique_letter_stream dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.letter          (letter),
		.first_of_string (first_of_string),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.found           (found),
		.unique_letter   (unique_letter)
	);

	task automatic report_error(input string what, input int got, input int want);
		error_count++;
		$display("%0t: error: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic clear_tally();
		for (int i = 0; i < ALPHA; i++) begin
			letter_hits[i] = 2'd0;
		end
		order_head = 0;
		order_tail = 0;
		order_fill = 0;
	endtask

	// earliest letter seen exactly once, after taking one letter code
	task automatic predict_unique(input logic [LW-1:0] code, input logic restart,
		output answer_t ans);
		if (restart)
			clear_tally();
		if (code < ALPHA) begin
			if (letter_hits[code] < 2'd2)
				letter_hits[code] = letter_hits[code] + 2'd1;
			// first sighting joins the order ring
			if (letter_hits[code] == 2'd1 && order_fill < ALPHA) begin
				arrival_order[order_tail] = code;
				order_tail = (order_tail + 1) % ALPHA;
				order_fill++;
			end
		end
		// drop heads that have repeated since
		while (order_fill > 0 && letter_hits[arrival_order[order_head]] > 2'd1) begin
			order_head = (order_head + 1) % ALPHA;
			order_fill--;
		end
		ans.found  = (order_fill > 0);
		ans.letter = (order_fill > 0) ? arrival_order[order_head] : '0;
	endtask

	// predict on every request transfer, check every response transfer
	always @(posedge clk or negedge arst_n) begin : check_answers
		answer_t ans;
		answer_t want;
		if (!arst_n) begin
			clear_tally();
		end else begin
			if (req_valid && !req_stall) begin
				predict_unique(letter, first_of_string, ans);
				if (item_typed) begin
					ans.found  = item_found;
					ans.letter = item_letter;
				end
				pending_answers.push_back(ans);
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					report_error("unexpected response, letter", int'(unique_letter), 0);
				end else begin
					want = pending_answers.pop_front();
					if (found !== want.found)
						report_error("found", int'(found), int'(want.found));
					if (unique_letter !== want.letter)
						report_error("unique_letter", int'(unique_letter),
							int'(want.letter));
				end
			end
		end
	end

	// receiver stalls on about ten percent of clocks, never while calm
	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
	end

	// watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("first_unique_letter_stream: mismatch");
				$finish;
			end
		end
	end

	// one request transfer, with an optional idle gap ahead of it
	task automatic send_item(input logic [LW-1:0] code, input logic restart,
		input logic typed = 1'b0, input logic exp_found = 1'b0,
		input logic [LW-1:0] exp_letter = '0);
		calm <= (sent_count >= 200 && sent_count < 300);
		if (!calm && $urandom_range(0, 99) < 10) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid       <= 1'b1;
		letter          <= code;
		first_of_string <= restart;
		item_typed      <= typed;
		item_found      <= exp_found;
		item_letter     <= exp_letter;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
	endtask

	initial begin : stimulus
		int kind;
		int span;
		int base;
		int len;
		int pick;
		int swap;
		logic drained;
		logic restart;
		int perm [ALPHA];

		drained = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			send_item(DIRECTED[r].code, DIRECTED[r].restart, DIRECTED[r].typed,
				DIRECTED[r].exp_found, DIRECTED[r].exp_letter);
		end

		while (sent_count < TOTAL_ITEMS) begin
			// once, let every answer come back before going on
			if (!drained && sent_count >= 120) begin
				drained = 1'b1;
				req_valid <= 1'b0;
				do @(posedge clk); while (pending_answers.size() != 0);
			end
			kind = $urandom_range(0, 9);
			// most strings open with a clear, a few continue the old one
			restart = ($urandom_range(0, 7) != 0);
			if (kind == 0) begin
				// noise: any code, any flag
				repeat ($urandom_range(1, 5))
					send_item(LW'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
			end else if (kind == 1) begin
				// whole alphabet once in shuffled order, then repeats to drain the ring
				for (int i = 0; i < ALPHA; i++)
					perm[i] = i;
				for (int i = ALPHA - 1; i > 0; i--) begin
					pick = $urandom_range(0, i);
					swap = perm[i];
					perm[i] = perm[pick];
					perm[pick] = swap;
				end
				for (int i = 0; i < ALPHA; i++)
					send_item(LW'(perm[i]), restart && i == 0);
				repeat ($urandom_range(5, 30))
					send_item(LW'($urandom_range(0, ALPHA - 1)), 1'b0);
			end else begin
				// string over a random span of letters, now and then an out of range code
				span = $urandom_range(2, ALPHA);
				base = $urandom_range(0, ALPHA - span);
				len  = $urandom_range(1, 30);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0)
						pick = $urandom_range(ALPHA, 31);
					else
						pick = base + $urandom_range(0, span - 1);
					send_item(LW'(pick), restart && i == 0);
				end
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("first_unique_letter_stream: match");
		else
			$display("first_unique_letter_stream: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/core/fuls_pkg.sv
rtl/core/fuls_ctrl.sv
rtl/core/fuls_dp.sv
rtl/core/first_unique_letter_stream.sv
test/tb_first_unique_letter_stream.sv
